/* rtl/core/tpcpb_pkg.sv */
// shared types and constants of the hit to point builder
package tpcpb_pkg;

	// input kinds carried on tuser
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_HIT   = 2'd1;
	localparam logic [1:0] ACT_DRAIN = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	// plane codes
	localparam logic [1:0] PLANE_U    = 2'd0;
	localparam logic [1:0] PLANE_V    = 2'd1;
	localparam logic [1:0] PLANE_W    = 2'd2;
	localparam logic [1:0] PLANE_NONE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_U_AXIS_X   = 3'd0;
	localparam logic [2:0] REG_U_AXIS_Y   = 3'd1;
	localparam logic [2:0] REG_V_AXIS_X   = 3'd2;
	localparam logic [2:0] REG_V_AXIS_Y   = 3'd3;
	localparam logic [2:0] REG_REF_X      = 3'd4;
	localparam logic [2:0] REG_REF_Y      = 3'd5;
	localparam logic [2:0] REG_MM_PER_BIN = 3'd6;
	localparam logic [2:0] REG_TRIG_BIN   = 3'd7;

	// arithmetic widths
	localparam int UW = 42;   // projected strip coordinate, Q.22
	localparam int NW = 59;   // divider numerator
	localparam int DW = 32;   // determinant
	localparam int QW = 24;   // quotient bits kept

	// reciprocal of three for an 18 bit sum
	localparam logic [17:0] RECIP3 = 18'd174763;
	localparam int RECIP3_SH = 19;

	localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SAT_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [23:0] rx;
		logic signed [23:0] ry;
		logic [23:0]        mpb;
		logic [19:0]        trig;
	} cfg_t;

	// drain job handed from front to back
	typedef struct packed {
		logic [8:0]         bin;
		logic signed [23:0] off_u;
		logic signed [23:0] off_v;
		logic [17:0]        qsum;
	} job_t;

	// per bin record
	typedef struct packed {
		logic [2:0][1:0] cnt;
		logic [9:0]      su;
		logic [9:0]      sv;
		logic [15:0]     qu;
		logic [15:0]     qv;
		logic [15:0]     qw;
	} bin_rec_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [15:0]        cavg;
		logic [8:0]         bin;
		logic               par;
	} point_t;

endpackage

/* rtl/core/tpc_hit_to_point_builder.sv */
// top level of the strip hit to 3d point builder
//
// Input stream s_*: tuser carries the item kind (offset load, hit, drain),
// tdata the plane, strip, time bin, charge and offset. Output stream m_*:
// one point per drain of a bin that saw exactly one U, V and W hit.
// Configuration registers are written through cfg_* (index, data), always
// ready; write them only while the block is idle.
// A load is taken while idle; a hit reads and then writes the bin store; a
// drain reads the record, clears its counts and, when it yields a point, goes
// on to two offset table reads and a queue push. For each point the back end
// runs its multiply and numerator setup and, unless the determinant is zero,
// two divisions of up to 24 steps on one shared divider, which sets the point
// rate. A two entry job queue lets hits keep flowing while a point is solved.
// After reset the bin store is cleared one bin per cycle, with s_tready low.
// A stalled m_tready holds the point and the back end; the front end stalls
// once the job queue is full.
module tpc_hit_to_point_builder #(
	parameter int NUM_STRIPS = 1024,
	parameter int NUM_BINS   = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // plane, strip, time bin, charge, offset_value
	input  logic [1:0]   s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // point_bin, x_out, y_out, z_out, charge_avg
	output logic         m_tuser,   // parallel_error
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	tpcpb_pkg::cfg_t   cfg_q;
	tpcpb_pkg::job_t   push_data, pop_data;
	tpcpb_pkg::point_t pt;
	logic push, pop, full, empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ax   <= 16'sd16384;
			cfg_q.ay   <= 16'sd0;
			cfg_q.vx   <= -16'sd8192;
			cfg_q.vy   <= 16'sd14189;
			cfg_q.rx   <= 24'sd0;
			cfg_q.ry   <= 24'sd0;
			cfg_q.mpb  <= 24'd65536;
			cfg_q.trig <= 20'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tpcpb_pkg::REG_U_AXIS_X:   cfg_q.ax   <= cfg_data[15:0];
				tpcpb_pkg::REG_U_AXIS_Y:   cfg_q.ay   <= cfg_data[15:0];
				tpcpb_pkg::REG_V_AXIS_X:   cfg_q.vx   <= cfg_data[15:0];
				tpcpb_pkg::REG_V_AXIS_Y:   cfg_q.vy   <= cfg_data[15:0];
				tpcpb_pkg::REG_REF_X:      cfg_q.rx   <= cfg_data;
				tpcpb_pkg::REG_REF_Y:      cfg_q.ry   <= cfg_data;
				tpcpb_pkg::REG_MM_PER_BIN: cfg_q.mpb  <= cfg_data;
				tpcpb_pkg::REG_TRIG_BIN:   cfg_q.trig <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	tpcpb_front #(
		.NUM_STRIPS (NUM_STRIPS),
		.NUM_BINS   (NUM_BINS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.action       (s_tuser),
		.plane        (s_tdata[1:0]),
		.strip        (s_tdata[11:2]),
		.hit_bin      (s_tdata[20:12]),
		.charge       (s_tdata[36:21]),
		.offset_value (s_tdata[60:37]),
		.job_push     (push),
		.job_data     (push_data),
		.job_full     (full)
	);

	tpcpb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	tpcpb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (empty),
		.job       (pop_data),
		.job_pop   (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pt        (pt)
	);

	assign m_tdata = {7'd0, pt.cavg, pt.z, pt.y, pt.x, pt.bin};
	assign m_tuser = pt.par;
endmodule

/* rtl/core/tpcpb_fifo.sv */
// two entry job queue between front and back
module tpcpb_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tpcpb_pkg::job_t  push_data,
	output logic             full,
	input  logic             pop,
	output tpcpb_pkg::job_t  pop_data,
	output logic             empty
);
	tpcpb_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_data = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule

/* rtl/core/tpcpb_front.sv */
// front end: offset table loads, per bin hit store and drain job issue
module tpcpb_front #(
	parameter int NUM_STRIPS = 1024,
	parameter int NUM_BINS   = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [1:0]       plane,
	input  logic [9:0]       strip,
	input  logic [8:0]       hit_bin,
	input  logic [15:0]      charge,
	input  logic [23:0]      offset_value,
	output logic             job_push,
	output tpcpb_pkg::job_t  job_data,
	input  logic             job_full
);
	localparam int SW = $clog2(NUM_STRIPS);
	localparam int BW = $clog2(NUM_BINS);

	typedef enum logic [2:0] {F_CLEAR, F_IDLE, F_UPD, F_OFFU, F_OFFV, F_PUSH} fstate_t;

	fstate_t state_q;
	logic [BW:0] clr_q;
	logic [1:0]  act_q, plane_q;
	logic [9:0]  strip_q;
	logic [8:0]  bin_q;
	logic [15:0] charge_q;
	logic [23:0] offu_q, offv_q;
	logic [17:0] qsum_q;

	tpcpb_pkg::bin_rec_t bin_mem [NUM_BINS];
	tpcpb_pkg::bin_rec_t bm_rd_q, bm_wd, upd;
	logic [BW-1:0] bm_ra, bm_wa;
	logic          bm_we;

	logic [23:0]   ot_mem [2*NUM_STRIPS];
	logic [23:0]   ot_rd_q;
	logic [SW:0]   ot_ra, ot_wa;
	logic          ot_we;

	logic accept, bin_ok, strip_ok, hit_ok, full_bin;
	logic [1:0] c;

	assign in_ready = state_q == F_IDLE;
	assign accept   = in_valid && in_ready;
	assign bin_ok   = 32'(hit_bin) < NUM_BINS;
	assign strip_ok = 32'(strip) < NUM_STRIPS;
	assign hit_ok   = (action == tpcpb_pkg::ACT_HIT) && plane != tpcpb_pkg::PLANE_NONE &&
		strip_ok && bin_ok;

	// offset table write on load, reads of the two drained strips
	assign ot_we = accept && action == tpcpb_pkg::ACT_LOAD && !plane[1] && strip_ok;
	assign ot_wa = {plane[0], SW'(strip)};
	always_comb begin
		case (state_q)
			F_OFFU:  ot_ra = {1'b1, SW'(bm_rd_q.sv)};
			default: ot_ra = {1'b0, SW'(bm_rd_q.su)};
		endcase
	end

	always_ff @(posedge clk) begin
		if (ot_we) ot_mem[ot_wa] <= offset_value;
		ot_rd_q <= ot_mem[ot_ra];
	end

	// hit record update, or count clear on a drain
	always_comb begin
		upd = bm_rd_q;
		c   = bm_rd_q.cnt[plane_q];
		if (c == 2'd0) begin
			case (plane_q)
				tpcpb_pkg::PLANE_U: begin
					upd.su = strip_q;
					upd.qu = charge_q;
				end
				tpcpb_pkg::PLANE_V: begin
					upd.sv = strip_q;
					upd.qv = charge_q;
				end
				default: upd.qw = charge_q;
			endcase
		end
		if (c != 2'd2) upd.cnt[plane_q] = c + 2'd1;
		if (act_q == tpcpb_pkg::ACT_DRAIN) begin
			upd     = bm_rd_q;
			upd.cnt = '0;
		end
	end

	assign full_bin = bm_rd_q.cnt[0] == 2'd1 && bm_rd_q.cnt[1] == 2'd1 &&
		bm_rd_q.cnt[2] == 2'd1;

	// bin store port control
	always_comb begin
		bm_ra = BW'(hit_bin);
		bm_we = 1'b0;
		bm_wa = BW'(bin_q);
		bm_wd = upd;
		case (state_q)
			F_CLEAR: begin
				bm_we = 32'(clr_q) < NUM_BINS;
				bm_wa = clr_q[BW-1:0];
				bm_wd = '0;
			end
			F_UPD:   bm_we = 1'b1;
			default: bm_we = 1'b0;
		endcase
	end

	// record is read at the accepting edge and held while the item is worked on
	always_ff @(posedge clk) begin
		if (bm_we) bin_mem[bm_wa] <= bm_wd;
		if (state_q == F_IDLE) bm_rd_q <= bin_mem[bm_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				F_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) >= NUM_BINS - 1) state_q <= F_IDLE;
				end
				F_IDLE: begin
					if (accept && (hit_ok || (action == tpcpb_pkg::ACT_DRAIN && bin_ok)))
						state_q <= F_UPD;
				end
				F_UPD: begin
					if (act_q == tpcpb_pkg::ACT_DRAIN && full_bin) state_q <= F_OFFU;
					else state_q <= F_IDLE;
				end
				F_OFFU:  state_q <= F_OFFV;
				F_OFFV:  state_q <= F_PUSH;
				F_PUSH:  if (!job_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// item and job payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			plane_q  <= plane;
			strip_q  <= strip;
			bin_q    <= hit_bin;
			charge_q <= charge;
		end
		if (state_q == F_UPD)
			qsum_q <= 18'(bm_rd_q.qu) + 18'(bm_rd_q.qv) + 18'(bm_rd_q.qw);
		if (state_q == F_OFFU) offu_q <= ot_rd_q;
		if (state_q == F_OFFV) offv_q <= ot_rd_q;
	end

	assign job_push       = state_q == F_PUSH && !job_full;
	assign job_data.bin   = bin_q;
	assign job_data.off_u = offu_q;
	assign job_data.off_v = offv_q;
	assign job_data.qsum  = qsum_q;
endmodule

/* rtl/core/tpcpb_div.sv */
// signed restoring divider, one quotient bit per cycle, saturating to 24 bits
module tpcpb_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [tpcpb_pkg::NW-1:0]  num,
	input  logic signed [tpcpb_pkg::DW-1:0]  den,
	output logic                             done,
	output logic signed [23:0]               quo
);
	localparam int NW = tpcpb_pkg::NW;
	localparam int DW = tpcpb_pkg::DW;
	localparam int QW = tpcpb_pkg::QW;

	logic          busy_q, done_q, neg_q, ovf_q;
	logic [4:0]    cnt_q;
	logic [NW-1:0] rem_q, dsh_q, na;
	logic [DW-1:0] da;
	logic [QW-1:0] mag_q;
	logic          neg, ovf, ge;

	assign neg = num[NW-1] ^ den[DW-1];
	assign na  = num[NW-1] ? NW'(-num) : NW'(num);
	assign da  = den[DW-1] ? DW'(-den) : DW'(den);
	assign ovf = na >= NW'({da, {QW{1'b0}}});
	assign ge  = rem_q >= dsh_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= 5'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg;
			ovf_q <= ovf;
			rem_q <= na;
			dsh_q <= NW'({da, {(QW-1){1'b0}}});
			mag_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			mag_q <= {mag_q[QW-2:0], ge};
		end
	end

	// sign and saturate
	always_comb begin
		if (ovf_q) quo = neg_q ? tpcpb_pkg::SAT_MIN : tpcpb_pkg::SAT_MAX;
		else if (!neg_q) quo = mag_q[QW-1] ? tpcpb_pkg::SAT_MAX : $signed(mag_q);
		else if (mag_q > 24'h800000) quo = tpcpb_pkg::SAT_MIN;
		else quo = $signed(-mag_q);
	end

	assign done = done_q;
endmodule

/* rtl/core/tpcpb_back.sv */
// back end: coordinate solve, drift position and charge mean for drain jobs
module tpcpb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tpcpb_pkg::cfg_t   cfg,
	input  logic              job_empty,
	input  tpcpb_pkg::job_t   job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output tpcpb_pkg::point_t pt
);
	localparam int UW = tpcpb_pkg::UW;
	localparam int NW = tpcpb_pkg::NW;
	localparam int DW = tpcpb_pkg::DW;

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_NUM, B_XGO, B_XWT, B_YGO, B_YWT, B_OUT} bstate_t;

	bstate_t state_q;
	tpcpb_pkg::job_t job_q;
	logic signed [UW-1:0] u_s1, v_s1;
	logic signed [DW-1:0] det_s1;
	logic signed [46:0]   zp_s1;
	logic [35:0]          cq_s1;
	logic signed [NW-1:0] numx_s2, numy_s2;
	tpcpb_pkg::point_t    pt_q;
	logic                 div_start, div_done;
	logic signed [NW-1:0] div_num;
	logic signed [23:0]   div_quo;
	logic signed [21:0]   dz;
	logic signed [30:0]   zq;

	assign job_pop   = state_q == B_IDLE && !job_empty;
	assign div_start = state_q == B_XGO || state_q == B_YGO;
	assign div_num   = state_q == B_XGO ? numx_s2 : numy_s2;

	tpcpb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_s1),
		.done   (div_done),
		.quo    (div_quo)
	);

	// drift offset in bins, Q.8
	assign dz = $signed({5'd0, job_q.bin, 8'd0}) - $signed({2'd0, cfg.trig});
	// divide by 65536 toward zero
	assign zq = zp_s1[46] ? 31'((zp_s1 + 47'sd65535) >>> 16) : 31'(zp_s1 >>> 16);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE:  if (!job_empty) state_q <= B_MUL;
				B_MUL:   state_q <= B_NUM;
				B_NUM:   state_q <= (det_s1 == '0) ? B_OUT : B_XGO;
				B_XGO:   state_q <= B_XWT;
				B_XWT:   if (div_done) state_q <= B_YGO;
				B_YGO:   state_q <= B_YWT;
				B_YWT:   if (div_done) state_q <= B_OUT;
				B_OUT:   if (out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		if (state_q == B_MUL) begin
			u_s1   <= UW'(cfg.rx * cfg.ax) + UW'(cfg.ry * cfg.ay) +
				(UW'(job_q.off_u) <<< 14);
			v_s1   <= UW'(cfg.rx * cfg.vx) + UW'(cfg.ry * cfg.vy) +
				(UW'(job_q.off_v) <<< 14);
			det_s1 <= DW'(cfg.ax * cfg.vy) - DW'(cfg.ay * cfg.vx);
			zp_s1  <= 47'(dz * $signed({1'b0, cfg.mpb}));
			cq_s1  <= job_q.qsum * tpcpb_pkg::RECIP3;
		end
		if (state_q == B_NUM) begin
			numx_s2     <= NW'(u_s1 * cfg.vy) - NW'(v_s1 * cfg.ay);
			numy_s2     <= NW'(cfg.ax * v_s1) - NW'(cfg.vx * u_s1);
			pt_q.bin    <= job_q.bin;
			pt_q.cavg   <= 16'(cq_s1 >> tpcpb_pkg::RECIP3_SH);
			pt_q.par    <= det_s1 == '0;
			pt_q.x      <= '0;
			pt_q.y      <= '0;
			if (zq > 31'sd8388607) pt_q.z <= tpcpb_pkg::SAT_MAX;
			else if (zq < -31'sd8388608) pt_q.z <= tpcpb_pkg::SAT_MIN;
			else pt_q.z <= 24'(zq);
		end
		if (state_q == B_XWT && div_done) pt_q.x <= div_quo;
		if (state_q == B_YWT && div_done) pt_q.y <= div_quo;
	end

	assign out_valid = state_q == B_OUT;
	assign pt        = pt_q;
endmodule
